// ===== hdl/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types, codes and defaults for the frame fragment reassembly unit.
// ----------------------------------------------------------------------------
package ufr_pkg;

  localparam int SLOTS_DEF             = 16;
  localparam int MAX_FRAGMENTS_DEF     = 64;
  localparam int HEADER_SIZE_DEF       = 40;
  localparam int FRAME_BYTES_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH           = 2;

  localparam logic [15:0] MAX_DATAGRAM = 16'd65507;

  localparam logic [24:0] MAX_FRAME_BYTES_RST = 25'd16777216;
  localparam logic [3:0]  MAX_PENDING_RST     = 4'd8;
  localparam logic [15:0] TIMEOUT_RST         = 16'd100;
  localparam logic [31:0] MAGIC_RST           = 32'd0;
  localparam logic [15:0] VERSION_RST         = 16'd1;

  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_TICK    = 3'd4;

  typedef enum logic [2:0] {
    CFG_MAX_FRAME_BYTES = 3'd0,
    CFG_MAX_PENDING     = 3'd1,
    CFG_TIMEOUT         = 3'd2,
    CFG_MAGIC           = 3'd3,
    CFG_VERSION         = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_DGRAM,
    JOB_TICK,
    JOB_BAD
  } job_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_FIND,
    S_OLD,
    S_ALLOC,
    S_TOUCH,
    S_RANGE,
    S_BYTES,
    S_LIMIT,
    S_OUT
  } back_state_t;

  typedef struct packed {
    logic [24:0] max_frame_bytes;
    logic [3:0]  max_pending;
    logic [15:0] timeout;
    logic [31:0] magic;
    logic [15:0] version;
  } ufr_cfg_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [63:0] frame_id;
    logic [63:0] stamp;
    logic [31:0] frame_bytes;
    logic [31:0] fragment_offset;
    logic [15:0] fragment_index;
    logic [15:0] fragment_total;
    logic [31:0] payload_bytes;
  } ufr_job_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [23:0] write_offset;
    logic [63:0] done_frame_id;
    logic [63:0] done_stamp;
    logic [6:0]  done_fragments;
    logic [4:0]  dropped;
  } ufr_res_t;

endpackage

// ===== hdl/ufr_if.sv =====
// ----------------------------------------------------------------------------
// ufr_if
// Valid/ready channels for datagram/tick words and result words.
// ----------------------------------------------------------------------------
interface ufr_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] datagram_bytes;
  logic [31:0] magic;
  logic [15:0] version;
  logic [15:0] header_bytes;
  logic [63:0] frame_id;
  logic [63:0] stamp;
  logic [31:0] frame_bytes;
  logic [31:0] fragment_offset;
  logic [15:0] fragment_index;
  logic [15:0] fragment_total;
  logic [31:0] payload_bytes;

  modport source (
    output valid, op, datagram_bytes, magic, version, header_bytes, frame_id, stamp,
           frame_bytes, fragment_offset, fragment_index, fragment_total, payload_bytes,
    input  ready
  );
  modport sink (
    input  valid, op, datagram_bytes, magic, version, header_bytes, frame_id, stamp,
           frame_bytes, fragment_offset, fragment_index, fragment_total, payload_bytes,
    output ready
  );
endinterface

interface ufr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [23:0] write_offset;
  logic [63:0] done_frame_id;
  logic [63:0] done_stamp;
  logic [6:0]  done_fragments;
  logic [4:0]  dropped;

  modport source (
    output valid, status, slot, write_offset, done_frame_id, done_stamp, done_fragments,
           dropped,
    input  ready
  );
  modport sink (
    input  valid, status, slot, write_offset, done_frame_id, done_stamp, done_fragments,
           dropped,
    output ready
  );
endinterface

// ===== hdl/ufr_front.sv =====
// ----------------------------------------------------------------------------
// ufr_front
// Accepts input words, checks header and fragment bounds, classifies jobs.
// ----------------------------------------------------------------------------
module ufr_front #(
  parameter int HEADER_SIZE       = ufr_pkg::HEADER_SIZE_DEF,
  parameter int MAX_FRAGMENTS     = ufr_pkg::MAX_FRAGMENTS_DEF,
  parameter int FRAME_BYTES_WIDTH = ufr_pkg::FRAME_BYTES_WIDTH_DEF
) (
  ufr_in_if.sink           in_ch,
  input  ufr_pkg::ufr_cfg_t cfg,
  output logic             push_valid,
  input  logic             push_ready,
  output ufr_pkg::ufr_job_t push_job
);

  localparam logic [32:0] CAP = 33'd1 << FRAME_BYTES_WIDTH;

  logic [32:0] limit;
  logic [15:0] actual;
  logic        hdr_bad;
  logic        frag_bad;

  assign limit  = ({8'd0, cfg.max_frame_bytes} > CAP) ? CAP : {8'd0, cfg.max_frame_bytes};
  assign actual = in_ch.datagram_bytes - in_ch.header_bytes;

  assign hdr_bad = (in_ch.datagram_bytes > ufr_pkg::MAX_DATAGRAM) ||
                   (in_ch.datagram_bytes < 16'(HEADER_SIZE)) ||
                   (in_ch.magic != cfg.magic) || (in_ch.version != cfg.version) ||
                   (in_ch.header_bytes != 16'(HEADER_SIZE)) ||
                   (in_ch.datagram_bytes < in_ch.header_bytes);

  assign frag_bad = (in_ch.frame_bytes == 32'd0) || ({1'b0, in_ch.frame_bytes} > limit) ||
                    (in_ch.fragment_total == 16'd0) ||
                    (in_ch.fragment_total > 16'(MAX_FRAGMENTS)) ||
                    (in_ch.fragment_index >= in_ch.fragment_total) ||
                    (in_ch.payload_bytes == 32'd0) ||
                    (in_ch.payload_bytes != {16'd0, actual}) ||
                    (in_ch.fragment_offset > in_ch.frame_bytes) ||
                    (in_ch.payload_bytes > in_ch.frame_bytes - in_ch.fragment_offset);

  always_comb begin
    push_job.frame_id        = in_ch.frame_id;
    push_job.stamp           = in_ch.stamp;
    push_job.frame_bytes     = in_ch.frame_bytes;
    push_job.fragment_offset = in_ch.fragment_offset;
    push_job.fragment_index  = in_ch.fragment_index;
    push_job.fragment_total  = in_ch.fragment_total;
    push_job.payload_bytes   = in_ch.payload_bytes;
    if (in_ch.op) begin
      push_job.kind = ufr_pkg::JOB_TICK;
    end else if (hdr_bad || frag_bad) begin
      push_job.kind = ufr_pkg::JOB_BAD;
    end else begin
      push_job.kind = ufr_pkg::JOB_DGRAM;
    end
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

// ===== hdl/ufr_queue.sv =====
// ----------------------------------------------------------------------------
// ufr_queue
// Short job queue between the classifier and the slot engine.
// ----------------------------------------------------------------------------
module ufr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  ufr_pkg::ufr_job_t push_job,
  output logic              pop_valid,
  input  logic              pop,
  output ufr_pkg::ufr_job_t pop_job
);

  localparam int DEPTH = ufr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  ufr_pkg::ufr_job_t entry_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = cnt_r != NW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = entry_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/ufr_back.sv =====
// ----------------------------------------------------------------------------
// ufr_back
// Slot engine: lookup, allocation, eviction, duplicate and overlap checks,
// timeouts, and the result register.
// ----------------------------------------------------------------------------
module ufr_back #(
  parameter int SLOTS             = ufr_pkg::SLOTS_DEF,
  parameter int MAX_FRAGMENTS     = ufr_pkg::MAX_FRAGMENTS_DEF,
  parameter int FRAME_BYTES_WIDTH = ufr_pkg::FRAME_BYTES_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ufr_pkg::ufr_cfg_t cfg,
  input  logic              q_valid,
  input  ufr_pkg::ufr_job_t q_job,
  output logic              q_pop,
  ufr_out_if.source         out_ch
);

  localparam int SW = $clog2(SLOTS);
  localparam int IW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int CW = $clog2(MAX_FRAGMENTS + 1);
  localparam int FW = (FRAME_BYTES_WIDTH < 32) ? FRAME_BYTES_WIDTH + 1 : 32;
  localparam int RD = SLOTS * MAX_FRAGMENTS;
  localparam int AW = $clog2(RD);

  ufr_pkg::back_state_t state_r, state_nxt;
  ufr_pkg::ufr_job_t    job_r, job_nxt;
  ufr_pkg::ufr_res_t    res_r, res_nxt;
  ufr_pkg::ufr_res_t    out_res_r;
  logic                 out_v_r, out_v_nxt;

  logic [31:0]       tick_r, tick_nxt;
  logic [SLOTS-1:0]  valid_r;
  logic [63:0]       fid_r   [SLOTS];
  logic [63:0]       stamp_r [SLOTS];
  logic [FW-1:0]     size_r  [SLOTS];
  logic [CW-1:0]     ftot_r  [SLOTS];
  logic [MAX_FRAGMENTS-1:0] map_r [SLOTS];
  logic [CW-1:0]     seen_r  [SLOTS];
  logic [FW-1:0]     bytes_r [SLOTS];
  logic [31:0]       touch_r [SLOTS];

  logic [2*FW-1:0]   rng_mem [RD];
  logic [2*FW-1:0]   rng_q;

  logic [SW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] free_r, free_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic          hit_r, hit_nxt;
  logic          bad_r, bad_nxt;
  logic          free_v_r, free_v_nxt;
  logic          best_v_r, best_v_nxt;
  logic [31:0]   best_age_r, best_age_nxt;
  logic [63:0]   best_fid_r, best_fid_nxt;
  logic [4:0]    drop_r, drop_nxt;
  logic          full_r, full_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic          cmp_v_r, cmp_v_nxt;

  logic          alloc_we, touch_we, upd_we, rng_re, val_clr;
  logic [SW-1:0] clr_idx;

  logic [FW-1:0] j_fbytes, j_foff, j_pbytes, j_fend;
  logic [CW-1:0] j_ftot;
  logic [IW-1:0] j_fidx;
  logic          cur_valid, cur_match, cur_bad, better, last;
  logic [31:0]   cur_age;
  logic          hit_any, bad_any, free_any, take_best, timed_out;
  logic [SW-1:0] free_fin, best_fin;
  logic [CW-1:0] seen_s, new_seen;
  logic [FW-1:0] bytes_s, new_bytes;
  logic          dup, ovl, issue, over, complete, excess;
  logic [SW:0]   n_valid;
  logic [3:0]    lim;
  logic [AW-1:0] rd_addr, wr_addr;

  function automatic logic [4:0] sat_inc(input logic [4:0] d);
    return (d == 5'd31) ? d : d + 5'd1;
  endfunction

  function automatic ufr_pkg::ufr_res_t mk_res(
    input logic [2:0] st, input logic [SW-1:0] sl, input logic [FW-1:0] off,
    input logic [63:0] fid, input logic [63:0] stp, input logic [CW-1:0] fr,
    input logic [4:0] dr);
    ufr_pkg::ufr_res_t r;
    r.status         = st;
    r.slot           = 4'(sl);
    r.write_offset   = 24'(off);
    r.done_frame_id  = fid;
    r.done_stamp     = stp;
    r.done_fragments = 7'(fr);
    r.dropped        = dr;
    return r;
  endfunction

  assign j_fbytes = job_r.frame_bytes[FW-1:0];
  assign j_foff   = job_r.fragment_offset[FW-1:0];
  assign j_pbytes = job_r.payload_bytes[FW-1:0];
  assign j_fend   = j_foff + j_pbytes;
  assign j_ftot   = job_r.fragment_total[CW-1:0];
  assign j_fidx   = job_r.fragment_index[IW-1:0];

  assign cur_valid = valid_r[idx_r];
  assign cur_age   = tick_r - touch_r[idx_r];
  assign cur_match = cur_valid && (fid_r[idx_r] == job_r.frame_id);
  assign cur_bad   = (stamp_r[idx_r] != job_r.stamp) || (size_r[idx_r] != j_fbytes) ||
                     (ftot_r[idx_r] != j_ftot);
  assign better    = !best_v_r || (cur_age > best_age_r) ||
                     ((cur_age == best_age_r) && (fid_r[idx_r] < best_fid_r));
  assign last      = idx_r == SW'(SLOTS - 1);
  assign timed_out = cur_valid && (cur_age > {16'd0, cfg.timeout});

  assign hit_any   = hit_r || cur_match;
  assign bad_any   = hit_r ? bad_r : cur_bad;
  assign free_any  = free_v_r || !cur_valid;
  assign free_fin  = (!free_v_r && !cur_valid) ? idx_r : free_r;
  assign take_best = cur_valid && better;
  assign best_fin  = take_best ? idx_r : best_r;

  assign seen_s    = seen_r[s_r];
  assign bytes_s   = bytes_r[s_r];
  assign dup       = map_r[s_r][j_fidx];
  assign ovl       = cmp_v_r && (j_foff < rng_q[FW-1:0]) && (j_fend > rng_q[2*FW-1:FW]);
  assign issue     = rd_r < seen_s;
  assign over      = j_pbytes > (j_fbytes - bytes_s);
  assign new_seen  = seen_s + 1'b1;
  assign new_bytes = bytes_s + j_pbytes;
  assign complete  = (new_seen == j_ftot) && (new_bytes == j_fbytes);
  assign n_valid   = (SW + 1)'($countones(valid_r));
  assign lim       = (cfg.max_pending == 4'd0) ? 4'd1 : cfg.max_pending;
  assign excess    = int'(n_valid) > int'(lim);

  assign rd_addr = AW'(s_r) * AW'(MAX_FRAGMENTS) + AW'(rd_r);
  assign wr_addr = AW'(s_r) * AW'(MAX_FRAGMENTS) + AW'(seen_s);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ufr_pkg::S_IDLE: begin
        if (q_valid) begin
          case (q_job.kind)
            ufr_pkg::JOB_TICK:  state_nxt = ufr_pkg::S_TICK;
            ufr_pkg::JOB_DGRAM: state_nxt = ufr_pkg::S_FIND;
            default:            state_nxt = ufr_pkg::S_OUT;
          endcase
        end
      end
      ufr_pkg::S_TICK: begin
        if (last) begin
          state_nxt = ufr_pkg::S_OUT;
        end
      end
      ufr_pkg::S_FIND: begin
        if (last) begin
          if (hit_any) begin
            state_nxt = bad_any ? ufr_pkg::S_OUT : ufr_pkg::S_TOUCH;
          end else if (free_any) begin
            state_nxt = ufr_pkg::S_ALLOC;
          end else begin
            state_nxt = ufr_pkg::S_OLD;
          end
        end
      end
      ufr_pkg::S_OLD: begin
        if (last) begin
          state_nxt = full_r ? ufr_pkg::S_ALLOC : ufr_pkg::S_LIMIT;
        end
      end
      ufr_pkg::S_ALLOC: state_nxt = ufr_pkg::S_TOUCH;
      ufr_pkg::S_TOUCH: begin
        if (dup) begin
          state_nxt = ufr_pkg::S_OUT;
        end else if (seen_s == '0) begin
          state_nxt = ufr_pkg::S_BYTES;
        end else begin
          state_nxt = ufr_pkg::S_RANGE;
        end
      end
      ufr_pkg::S_RANGE: begin
        if (ovl) begin
          state_nxt = ufr_pkg::S_OUT;
        end else if (!issue && !cmp_v_r) begin
          state_nxt = ufr_pkg::S_BYTES;
        end
      end
      ufr_pkg::S_BYTES: begin
        state_nxt = (over || complete) ? ufr_pkg::S_OUT : ufr_pkg::S_LIMIT;
      end
      ufr_pkg::S_LIMIT: begin
        state_nxt = excess ? ufr_pkg::S_OLD : ufr_pkg::S_OUT;
      end
      ufr_pkg::S_OUT: begin
        if (!out_v_r || out_ch.ready) begin
          state_nxt = ufr_pkg::S_IDLE;
        end
      end
      default: state_nxt = ufr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    job_nxt      = job_r;
    res_nxt      = res_r;
    tick_nxt     = tick_r;
    idx_nxt      = idx_r;
    s_nxt        = s_r;
    free_nxt     = free_r;
    best_nxt     = best_r;
    hit_nxt      = hit_r;
    bad_nxt      = bad_r;
    free_v_nxt   = free_v_r;
    best_v_nxt   = best_v_r;
    best_age_nxt = best_age_r;
    best_fid_nxt = best_fid_r;
    drop_nxt     = drop_r;
    full_nxt     = full_r;
    rd_nxt       = rd_r;
    cmp_v_nxt    = cmp_v_r;
    alloc_we     = 1'b0;
    touch_we     = 1'b0;
    upd_we       = 1'b0;
    rng_re       = 1'b0;
    val_clr      = 1'b0;
    clr_idx      = s_r;
    q_pop        = 1'b0;
    out_v_nxt    = out_v_r;
    if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    case (state_r)
      ufr_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          job_nxt    = q_job;
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
          free_v_nxt = 1'b0;
          drop_nxt   = '0;
          if (q_job.kind == ufr_pkg::JOB_TICK) begin
            tick_nxt = tick_r + 32'd1;
          end
          res_nxt = mk_res(ufr_pkg::ST_INVALID, '0, '0, '0, '0, '0, '0);
        end
      end
      ufr_pkg::S_TICK: begin
        idx_nxt = last ? '0 : idx_r + 1'b1;
        if (timed_out) begin
          val_clr  = 1'b1;
          clr_idx  = idx_r;
          drop_nxt = sat_inc(drop_r);
        end
        if (last) begin
          res_nxt = mk_res(ufr_pkg::ST_TICK, '0, '0, '0, '0, '0,
                           timed_out ? sat_inc(drop_r) : drop_r);
        end
      end
      ufr_pkg::S_FIND: begin
        idx_nxt = last ? '0 : idx_r + 1'b1;
        if (cur_match && !hit_r) begin
          hit_nxt = 1'b1;
          bad_nxt = cur_bad;
          s_nxt   = idx_r;
        end
        if (!cur_valid && !free_v_r) begin
          free_v_nxt = 1'b1;
          free_nxt   = idx_r;
        end
        if (last) begin
          if (hit_any) begin
            res_nxt = mk_res(ufr_pkg::ST_INVALID, '0, '0, '0, '0, '0, drop_r);
          end else if (free_any) begin
            s_nxt = free_fin;
          end else begin
            full_nxt   = 1'b1;
            best_v_nxt = 1'b0;
          end
        end
      end
      ufr_pkg::S_OLD: begin
        idx_nxt = last ? '0 : idx_r + 1'b1;
        if (take_best) begin
          best_v_nxt   = 1'b1;
          best_nxt     = idx_r;
          best_age_nxt = cur_age;
          best_fid_nxt = fid_r[idx_r];
        end
        if (last) begin
          drop_nxt = sat_inc(drop_r);
          if (full_r) begin
            s_nxt = best_fin;
          end else begin
            val_clr = 1'b1;
            clr_idx = best_fin;
          end
        end
      end
      ufr_pkg::S_ALLOC: alloc_we = 1'b1;
      ufr_pkg::S_TOUCH: begin
        touch_we  = 1'b1;
        rd_nxt    = '0;
        cmp_v_nxt = 1'b0;
        res_nxt   = mk_res(ufr_pkg::ST_DUP, '0, '0, '0, '0, '0, drop_r);
      end
      ufr_pkg::S_RANGE: begin
        if (ovl) begin
          res_nxt = mk_res(ufr_pkg::ST_INVALID, '0, '0, '0, '0, '0, drop_r);
        end else begin
          rng_re    = issue;
          cmp_v_nxt = issue;
          if (issue) begin
            rd_nxt = rd_r + 1'b1;
          end
        end
      end
      ufr_pkg::S_BYTES: begin
        if (over) begin
          res_nxt = mk_res(ufr_pkg::ST_INVALID, '0, '0, '0, '0, '0, drop_r);
        end else begin
          upd_we = 1'b1;
          if (complete) begin
            val_clr = 1'b1;
            clr_idx = s_r;
            res_nxt = mk_res(ufr_pkg::ST_DONE, s_r, j_foff, job_r.frame_id, job_r.stamp,
                             j_ftot, drop_r);
          end
        end
      end
      ufr_pkg::S_LIMIT: begin
        if (excess) begin
          full_nxt   = 1'b0;
          best_v_nxt = 1'b0;
          idx_nxt    = '0;
        end else begin
          res_nxt = mk_res(ufr_pkg::ST_PENDING, s_r, j_foff, '0, '0, '0, drop_r);
        end
      end
      ufr_pkg::S_OUT: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufr_pkg::S_IDLE;
      tick_r  <= '0;
      valid_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      out_v_r <= out_v_nxt;
      if (val_clr) begin
        valid_r[clr_idx] <= 1'b0;
      end
      if (alloc_we) begin
        valid_r[s_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    res_r      <= res_nxt;
    idx_r      <= idx_nxt;
    s_r        <= s_nxt;
    free_r     <= free_nxt;
    best_r     <= best_nxt;
    hit_r      <= hit_nxt;
    bad_r      <= bad_nxt;
    free_v_r   <= free_v_nxt;
    best_v_r   <= best_v_nxt;
    best_age_r <= best_age_nxt;
    best_fid_r <= best_fid_nxt;
    drop_r     <= drop_nxt;
    full_r     <= full_nxt;
    rd_r       <= rd_nxt;
    cmp_v_r    <= cmp_v_nxt;
    if (state_r == ufr_pkg::S_OUT && (!out_v_r || out_ch.ready)) begin
      out_res_r <= res_r;
    end
    if (alloc_we) begin
      fid_r[s_r]   <= job_r.frame_id;
      stamp_r[s_r] <= job_r.stamp;
      size_r[s_r]  <= j_fbytes;
      ftot_r[s_r]  <= j_ftot;
      map_r[s_r]   <= '0;
      seen_r[s_r]  <= '0;
      bytes_r[s_r] <= '0;
    end
    if (touch_we) begin
      touch_r[s_r] <= tick_r;
    end
    if (upd_we) begin
      map_r[s_r][j_fidx] <= 1'b1;
      seen_r[s_r]        <= new_seen;
      bytes_r[s_r]       <= new_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_we && (seen_s < CW'(MAX_FRAGMENTS))) begin
      rng_mem[wr_addr] <= {j_foff, j_fend};
    end
    if (rng_re) begin
      rng_q <= rng_mem[rd_addr];
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.slot           = out_res_r.slot;
  assign out_ch.write_offset   = out_res_r.write_offset;
  assign out_ch.done_frame_id  = out_res_r.done_frame_id;
  assign out_ch.done_stamp     = out_res_r.done_stamp;
  assign out_ch.done_fragments = out_res_r.done_fragments;
  assign out_ch.dropped        = out_res_r.dropped;

endmodule

// ===== hdl/udp_frame_fragment_reassembly_unit.sv =====
// ----------------------------------------------------------------------------
// udp_frame_fragment_reassembly_unit
// Fragment reassembly tracker for frames sent as numbered datagrams.
// ----------------------------------------------------------------------------
// Each input word is a parsed datagram header or a time tick and yields one
// result word. Header checks happen on entry; words then wait in a two-entry
// queue for the slot engine, which handles one word at a time. A tick makes
// one timeout check per slot. An accepted datagram goes through pop, one
// frame-id compare per slot, touch, byte check, pending-limit check and the
// result. A new frame adds a step to take a slot, and a pass over the slots
// to pick a victim when the table is full. A frame with ranges already stored
// reads each stored range from the range memory, one range per cycle (up to
// MAX_FRAGMENTS). Each eviction over the pending limit adds another pass over
// the slots. A duplicate fragment ends after the touch, a completing one skips
// the pending-limit check, an inconsistent header for a known frame ends after
// the compares, and a bad header goes straight to the result. A wait on the
// result channel stalls the engine. There is no clearing pass after reset.
// The result register lets the queue keep filling while a result waits.
module udp_frame_fragment_reassembly_unit #(
  parameter int SLOTS             = ufr_pkg::SLOTS_DEF,
  parameter int MAX_FRAGMENTS     = ufr_pkg::MAX_FRAGMENTS_DEF,
  parameter int HEADER_SIZE       = ufr_pkg::HEADER_SIZE_DEF,
  parameter int FRAME_BYTES_WIDTH = ufr_pkg::FRAME_BYTES_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ufr_in_if.sink      in_ch,
  ufr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ufr_pkg::ufr_cfg_t cfg_r;
  ufr_pkg::ufr_job_t push_job, pop_job;
  logic              push_valid, push_ready, pop_valid, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_bytes <= ufr_pkg::MAX_FRAME_BYTES_RST;
      cfg_r.max_pending     <= ufr_pkg::MAX_PENDING_RST;
      cfg_r.timeout         <= ufr_pkg::TIMEOUT_RST;
      cfg_r.magic           <= ufr_pkg::MAGIC_RST;
      cfg_r.version         <= ufr_pkg::VERSION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ufr_pkg::CFG_MAX_FRAME_BYTES: cfg_r.max_frame_bytes <= cfg_data[24:0];
        ufr_pkg::CFG_MAX_PENDING:     cfg_r.max_pending     <= cfg_data[3:0];
        ufr_pkg::CFG_TIMEOUT:         cfg_r.timeout         <= cfg_data[15:0];
        ufr_pkg::CFG_MAGIC:           cfg_r.magic           <= cfg_data;
        ufr_pkg::CFG_VERSION:         cfg_r.version         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ufr_front #(
    .HEADER_SIZE      (HEADER_SIZE),
    .MAX_FRAGMENTS    (MAX_FRAGMENTS),
    .FRAME_BYTES_WIDTH(FRAME_BYTES_WIDTH)
  ) u_front (
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  ufr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job)
  );

  ufr_back #(
    .SLOTS            (SLOTS),
    .MAX_FRAGMENTS    (MAX_FRAGMENTS),
    .FRAME_BYTES_WIDTH(FRAME_BYTES_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_valid(pop_valid),
    .q_job  (pop_job),
    .q_pop  (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== hdl/ufr_checker.sv =====
// ----------------------------------------------------------------------------
// ufr_checker
// Port-level checks on the result channel of the reassembly unit.
// ----------------------------------------------------------------------------
module ufr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [3:0]  out_slot,
  input logic [23:0] out_write_offset,
  input logic [63:0] out_done_frame_id,
  input logic [63:0] out_done_stamp,
  input logic [6:0]  out_done_fragments
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ufr_pkg::ST_PENDING) || (out_status == ufr_pkg::ST_DONE) ||
                  (out_status == ufr_pkg::ST_INVALID) || (out_status == ufr_pkg::ST_DUP) ||
                  (out_status == ufr_pkg::ST_TICK))
    else $error("bad status code");

  a_noslot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ufr_pkg::ST_PENDING && out_status != ufr_pkg::ST_DONE
      |-> out_slot == 4'd0 && out_write_offset == 24'd0)
    else $error("slot reported on rejected word");

  a_nodone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ufr_pkg::ST_DONE
      |-> out_done_frame_id == 64'd0 && out_done_stamp == 64'd0 && out_done_fragments == 7'd0)
    else $error("completion fields set without completion");

endmodule

bind udp_frame_fragment_reassembly_unit ufr_checker u_ufr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_slot          (out_ch.slot),
  .out_write_offset  (out_ch.write_offset),
  .out_done_frame_id (out_ch.done_frame_id),
  .out_done_stamp    (out_ch.done_stamp),
  .out_done_fragments(out_ch.done_fragments)
);
